[design/awc_pkg.sv]
// ----------------------------------------------------------------------------
// awc_pkg
// Shared types and constants of the terminal cell writer.
// ----------------------------------------------------------------------------
package awc_pkg;

  localparam int unsigned MAX_PARAMS_DEF  = 16;
  localparam int unsigned MAX_COLUMNS_DEF = 512;
  localparam int unsigned MAX_ROWS_DEF    = 256;

  localparam logic [9:0] COLS_RESET = 10'd80;
  localparam logic [8:0] ROWS_RESET = 9'd24;
  localparam logic [7:0] FORE_RESET = 8'd220;

  localparam logic [7:0] CH_ESC  = 8'h1b;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LBRK = 8'h5b;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_M    = 8'h6d;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_J    = 8'h4a;

  localparam logic [15:0] SGR_FORE = 16'd38;
  localparam logic [15:0] SGR_BACK = 16'd48;
  localparam logic [15:0] SGR_RGB  = 16'd2;
  localparam logic [15:0] CUR_MAX  = 16'hffff;

  typedef enum logic [0:0] {
    REG_GRID_COLUMNS = 1'b0,
    REG_GRID_ROWS    = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_kind_e;

  typedef enum logic [1:0] {
    MODE_GROUND = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_CSI    = 2'd2
  } parse_mode_e;

  typedef enum logic [2:0] {
    W_OFF,
    W_CODE,
    W_SEL,
    W_RED,
    W_GREEN,
    W_BLUE
  } walk_state_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [20:0] cp;
    logic [23:0] fore;
    logic [23:0] back;
  } cmd_t;

endpackage

[design/awc_front.sv]
// ----------------------------------------------------------------------------
// awc_front
// Byte parser: UTF-8 decode, control bytes, CSI parameters and SGR walk.
// ----------------------------------------------------------------------------
module awc_front #(
  parameter int unsigned MaxParams = awc_pkg::MAX_PARAMS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    byte_i,
  input  logic          first_i,
  input  logic          last_i,
  input  logic          space_i,
  output logic          cmd_valid_o,
  output awc_pkg::cmd_t cmd_o
);

  localparam int unsigned CW = $clog2(MaxParams + 1);
  localparam int unsigned IW = $clog2(MaxParams);

  awc_pkg::parse_mode_e mode_q, mode_d;
  awc_pkg::walk_state_e wst_q, wst_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic [23:0] fore_q, fore_d, back_q, back_d;
  logic [15:0] acc_q, acc_d, p0_q, p0_d, p1_q, p1_d;
  logic        seen_q, seen_d;
  logic [CW-1:0] cnt_q, cnt_d, wcnt_q, wcnt_d, k_q, k_d;
  logic [1:0]  rem_q, rem_d;
  logic [20:0] part_q, part_d;
  logic [7:0]  red_q, red_d, grn_q, grn_d;
  logic        selfore_q, selfore_d;
  logic [15:0] store_q [MaxParams];
  logic        st_we;
  logic [IW-1:0] st_wa, rd_addr;
  logic [15:0] st_wd, rd;
  logic [2:0]  off;
  logic        acc_in;

  assign in_ready_o = (wst_q == awc_pkg::W_OFF) && space_i;
  assign acc_in     = in_valid_i && in_ready_o;

  always_comb begin
    unique case (wst_q)
      awc_pkg::W_SEL:   off = 3'd1;
      awc_pkg::W_RED:   off = 3'd2;
      awc_pkg::W_GREEN: off = 3'd3;
      awc_pkg::W_BLUE:  off = 3'd4;
      default:          off = 3'd0;
    endcase
  end

  logic [CW+2:0] addr_sum;
  assign addr_sum = (CW+3)'(k_q) + (CW+3)'(off);
  assign rd_addr  = addr_sum[IW-1:0];
  assign rd       = store_q[rd_addr];

  // walk next state
  always_comb begin
    wst_d = wst_q;
    unique case (wst_q)
      awc_pkg::W_OFF: begin
        if (acc_in && rem_d == 2'd0 && mode_q == awc_pkg::MODE_CSI && !first_i
            && byte_i == awc_pkg::CH_M && wcnt_d != '0) begin
          wst_d = awc_pkg::W_CODE;
        end
      end
      awc_pkg::W_CODE: begin
        if (k_q >= wcnt_q) begin
          wst_d = awc_pkg::W_OFF;
        end else if ((rd == awc_pkg::SGR_FORE || rd == awc_pkg::SGR_BACK)
                     && ((CW+1)'(k_q) + (CW+1)'(4)) < (CW+1)'(wcnt_q)) begin
          wst_d = awc_pkg::W_SEL;
        end
      end
      awc_pkg::W_SEL:   wst_d = (rd == awc_pkg::SGR_RGB) ? awc_pkg::W_RED : awc_pkg::W_CODE;
      awc_pkg::W_RED:   wst_d = awc_pkg::W_GREEN;
      awc_pkg::W_GREEN: wst_d = awc_pkg::W_BLUE;
      awc_pkg::W_BLUE:  wst_d = awc_pkg::W_CODE;
      default:          wst_d = awc_pkg::W_OFF;
    endcase
  end

  // datapath
  always_comb begin
    logic [1:0]  need;
    logic [20:0] cp;
    logic        put;
    logic [15:0] pv;
    logic        push;
    logic [15:0] r0, c0;
    need = 2'd0; cp = 21'd0; put = 1'b0; pv = 16'd0; push = 1'b0;
    r0 = 16'd0; c0 = 16'd0;
    mode_d = mode_q; col_d = col_q; row_d = row_q; fore_d = fore_q; back_d = back_q;
    acc_d = acc_q; seen_d = seen_q; cnt_d = cnt_q; rem_d = rem_q; part_d = part_q;
    p0_d = p0_q; p1_d = p1_q; wcnt_d = wcnt_q; k_d = k_q;
    red_d = red_q; grn_d = grn_q; selfore_d = selfore_q;
    st_we = 1'b0; st_wa = '0; st_wd = 16'd0;
    cmd_valid_o = 1'b0;
    cmd_o = '0;
    if (acc_in) begin
      if (first_i) begin
        mode_d = awc_pkg::MODE_GROUND; col_d = '0; row_d = '0;
        fore_d = {3{awc_pkg::FORE_RESET}}; back_d = '0;
        acc_d = '0; seen_d = 1'b0; cnt_d = '0; rem_d = '0; part_d = '0;
      end
      if (rem_d != 2'd0) begin
        part_d = {part_d[14:0], byte_i[5:0]};
        rem_d  = rem_d - 2'd1;
        if (rem_d == 2'd0 || last_i) begin
          rem_d = 2'd0;
          put = 1'b1;
          cp  = part_d;
        end
      end else if (mode_d == awc_pkg::MODE_CSI) begin
        if (byte_i >= awc_pkg::CH_ZERO && byte_i <= awc_pkg::CH_NINE) begin
          acc_d  = {acc_d[12:0], 3'b000} + {acc_d[14:0], 1'b0}
                   + {12'd0, byte_i[3:0]};
          seen_d = 1'b1;
        end else if (byte_i == awc_pkg::CH_SEMI) begin
          push = 1'b1;
          pv = seen_d ? acc_d : 16'd0;
          acc_d = '0; seen_d = 1'b0;
        end else begin
          push = seen_d;
          pv = acc_d;
          mode_d = awc_pkg::MODE_GROUND;
          acc_d = '0; seen_d = 1'b0;
        end
      end else if (mode_d == awc_pkg::MODE_ESCAPE && byte_i == awc_pkg::CH_LBRK) begin
        mode_d = awc_pkg::MODE_CSI;
        acc_d = '0; seen_d = 1'b0; cnt_d = '0;
      end else begin
        mode_d = awc_pkg::MODE_GROUND;
        if (byte_i == awc_pkg::CH_ESC) begin
          mode_d = awc_pkg::MODE_ESCAPE;
        end else if (byte_i == awc_pkg::CH_LF) begin
          if (row_d != awc_pkg::CUR_MAX) row_d = row_d + 16'd1;
          col_d = '0;
        end else if (byte_i == awc_pkg::CH_CR) begin
          col_d = '0;
        end else if (byte_i >= 8'h20) begin
          cp = {13'd0, byte_i};
          if (byte_i[7:5] == 3'b110) begin
            need = 2'd1; cp = {16'd0, byte_i[4:0]};
          end else if (byte_i[7:4] == 4'b1110) begin
            need = 2'd2; cp = {17'd0, byte_i[3:0]};
          end else if (byte_i[7:3] == 5'b11110) begin
            need = 2'd3; cp = {18'd0, byte_i[2:0]};
          end
          if (need == 2'd0 || last_i) begin
            put = 1'b1;
          end else begin
            rem_d = need; part_d = cp;
          end
        end
      end
      if (push && cnt_d < CW'(MaxParams)) begin
        st_we = 1'b1;
        st_wa = cnt_d[IW-1:0];
        st_wd = pv;
        if (cnt_d == CW'(0)) p0_d = pv;
        if (cnt_d == CW'(1)) p1_d = pv;
        cnt_d = cnt_d + CW'(1);
      end
      if (!first_i && mode_q == awc_pkg::MODE_CSI && rem_q == 2'd0
          && mode_d == awc_pkg::MODE_GROUND) begin
        if (byte_i == awc_pkg::CH_M) begin
          if (cnt_d == '0) begin
            fore_d = {3{awc_pkg::FORE_RESET}}; back_d = '0;
          end
          wcnt_d = cnt_d;
          k_d = '0;
        end else if (byte_i == awc_pkg::CH_H || byte_i == awc_pkg::CH_F) begin
          r0 = (cnt_d >= CW'(1)) ? p0_d : 16'd1;
          c0 = (cnt_d >= CW'(2)) ? p1_d : 16'd1;
          row_d = (r0 != 16'd0) ? r0 - 16'd1 : 16'd0;
          col_d = (c0 != 16'd0) ? c0 - 16'd1 : 16'd0;
        end else if (byte_i == awc_pkg::CH_J) begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = awc_pkg::CMD_CLEAR;
        end
        cnt_d = '0;
      end
      if (put) begin
        cmd_valid_o = 1'b1;
        cmd_o.kind = awc_pkg::CMD_WRITE;
        cmd_o.row  = row_d;
        cmd_o.col  = col_d;
        cmd_o.cp   = cp;
        cmd_o.fore = fore_d;
        cmd_o.back = back_d;
        if (col_d != awc_pkg::CUR_MAX) col_d = col_d + 16'd1;
      end
      if (last_i) begin
        mode_d = awc_pkg::MODE_GROUND;
        rem_d = '0; part_d = '0; acc_d = '0; seen_d = 1'b0; cnt_d = '0;
      end
    end else begin
      unique case (wst_q)
        awc_pkg::W_CODE: begin
          if (k_q < wcnt_q) begin
            if (rd == 16'd0) begin
              fore_d = {3{awc_pkg::FORE_RESET}}; back_d = '0;
              k_d = k_q + CW'(1);
            end else if (wst_d == awc_pkg::W_SEL) begin
              selfore_d = (rd == awc_pkg::SGR_FORE);
            end else begin
              k_d = k_q + CW'(1);
            end
          end
        end
        awc_pkg::W_SEL: begin
          if (rd != awc_pkg::SGR_RGB) k_d = k_q + CW'(1);
        end
        awc_pkg::W_RED:   red_d = rd[7:0];
        awc_pkg::W_GREEN: grn_d = rd[7:0];
        awc_pkg::W_BLUE: begin
          if (selfore_q) fore_d = {red_q, grn_q, rd[7:0]};
          else back_d = {red_q, grn_q, rd[7:0]};
          k_d = k_q + CW'(5);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) store_q[st_wa] <= st_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= awc_pkg::MODE_GROUND; wst_q <= awc_pkg::W_OFF;
      col_q <= '0; row_q <= '0; fore_q <= {3{awc_pkg::FORE_RESET}}; back_q <= '0;
      acc_q <= '0; seen_q <= 1'b0; cnt_q <= '0; rem_q <= '0; part_q <= '0;
      p0_q <= '0; p1_q <= '0; wcnt_q <= '0; k_q <= '0;
      red_q <= '0; grn_q <= '0; selfore_q <= 1'b0;
    end else begin
      mode_q <= mode_d; wst_q <= wst_d;
      col_q <= col_d; row_q <= row_d; fore_q <= fore_d; back_q <= back_d;
      acc_q <= acc_d; seen_q <= seen_d; cnt_q <= cnt_d; rem_q <= rem_d; part_q <= part_d;
      p0_q <= p0_d; p1_q <= p1_d; wcnt_q <= wcnt_d; k_q <= k_d;
      red_q <= red_d; grn_q <= grn_d; selfore_q <= selfore_d;
    end
  end

  a_walk_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wst_q != awc_pkg::W_OFF |-> !in_ready_o) else $error("input taken during SGR walk");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxParams)) else $error("parameter count overflow");
  a_utf8_ground: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != 2'd0 |-> mode_q == awc_pkg::MODE_GROUND) else $error("utf8 outside ground");
  a_cmd_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> acc_in) else $error("command without input word");

endmodule

[design/awc_fifo.sv]
// ----------------------------------------------------------------------------
// awc_fifo
// Two-entry command queue between parser and cell stage.
// ----------------------------------------------------------------------------
module awc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  awc_pkg::cmd_t wdata_i,
  output logic          space_o,
  input  logic          pop_i,
  output logic          avail_o,
  output awc_pkg::cmd_t rdata_o
);

  awc_pkg::cmd_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign space_o = (cnt_q != 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[design/awc_back.sv]
// ----------------------------------------------------------------------------
// awc_back
// Cell stage: grid bounds check, cell index and output register.
// ----------------------------------------------------------------------------
module awc_back #(
  parameter int unsigned MaxColumns = awc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MaxRows    = awc_pkg::MAX_ROWS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [9:0]    cols_i,
  input  logic [8:0]    rows_i,
  input  logic          avail_i,
  input  awc_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic          kind_o,
  output logic [87:0]   data_o
);

  localparam int unsigned ECW = $clog2(MaxColumns + 1);
  localparam int unsigned ERW = $clog2(MaxRows + 1);
  localparam int unsigned IXW = (ECW + ERW + 1 > 17) ? ECW + ERW + 1 : 17;

  logic [ECW-1:0] ecols;
  logic [ERW-1:0] erows;
  logic           in_grid;
  logic [IXW-1:0] idx;
  logic           valid_q, valid_d;
  logic           kind_q, kind_d;
  logic [87:0]    data_q, data_d;

  always_comb begin
    if (cols_i == 10'd0) ecols = ECW'(1);
    else if (32'(cols_i) > MaxColumns) ecols = ECW'(MaxColumns);
    else ecols = ECW'(cols_i);
    if (rows_i == 9'd0) erows = ERW'(1);
    else if (32'(rows_i) > MaxRows) erows = ERW'(MaxRows);
    else erows = ERW'(rows_i);
  end

  assign in_grid = (32'(cmd_i.row) < 32'(erows)) && (32'(cmd_i.col) < 32'(ecols));
  assign idx = IXW'(cmd_i.row[ERW-1:0]) * IXW'(ecols) + IXW'(cmd_i.col[ECW-1:0]);
  assign pop_o = avail_i && (!valid_q || ready_i);

  always_comb begin
    valid_d = valid_q && !ready_i;
    kind_d  = kind_q;
    data_d  = data_q;
    if (pop_o) begin
      if (cmd_i.kind == awc_pkg::CMD_CLEAR) begin
        valid_d = 1'b1;
        kind_d  = 1'b1;
        data_d  = '0;
      end else begin
        valid_d = in_grid;
        kind_d  = 1'b0;
        data_d  = {2'b00, cmd_i.back[7:0], cmd_i.back[15:8], cmd_i.back[23:16],
                   cmd_i.fore[7:0], cmd_i.fore[15:8], cmd_i.fore[23:16],
                   cmd_i.cp, idx[16:0]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign data_o  = data_q;

endmodule

[design/ansi_utf8_terminal_cell_writer.sv]
// ----------------------------------------------------------------------------
// ansi_utf8_terminal_cell_writer
// Terminal byte stream to character-grid commands.
// ----------------------------------------------------------------------------
// Input stream: one byte per word on tdata[7:0]; tuser marks the first byte
// of a frame, tlast the last one. Output stream: one grid command per word,
// tuser is the command kind (0 write cell, 1 clear grid).
// Configuration: write grid_columns (index 0) or grid_rows (index 1) while
// the block is idle.
// Throughput: one byte per cycle while the queue has space. After the SGR
// final byte 'm' no byte is taken while the stored parameters are walked
// and applied to the colours.
// Each command is registered in the queue and then in the output register.
// A two-entry queue separates the parser from the output register, so a
// stalled receiver backs up the queue and then holds off the input.
// Reset clears parser, cursor, colours and queue; the grid returns to
// 80 columns by 24 rows.
// ----------------------------------------------------------------------------
module ansi_utf8_terminal_cell_writer #(
  parameter int unsigned MaxParams  = awc_pkg::MAX_PARAMS_DEF,
  parameter int unsigned MaxColumns = awc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MaxRows    = awc_pkg::MAX_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tuser_i,   // frame_start
  input  logic        s_axis_tlast_i,   // frame_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // cell_index, code_point, fore_red, fore_green, fore_blue,
  // back_red, back_green, back_blue, zero pad
  output logic [87:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // command_kind
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i
);

  logic [9:0] cols_q;
  logic [8:0] rows_q;
  logic       space, push, pop, avail;
  awc_pkg::cmd_t wcmd, rcmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= awc_pkg::COLS_RESET;
      rows_q <= awc_pkg::ROWS_RESET;
    end else if (cfg_we_i) begin
      unique case (awc_pkg::reg_idx_e'(cfg_idx_i))
        awc_pkg::REG_GRID_COLUMNS: cols_q <= cfg_wdata_i;
        awc_pkg::REG_GRID_ROWS:    rows_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  awc_front #(.MaxParams(MaxParams)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .byte_i     (s_axis_tdata_i),
    .first_i    (s_axis_tuser_i),
    .last_i     (s_axis_tlast_i),
    .space_i    (space),
    .cmd_valid_o(push),
    .cmd_o      (wcmd)
  );

  awc_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i (push),
    .wdata_i(wcmd),
    .space_o(space),
    .pop_i  (pop),
    .avail_o(avail),
    .rdata_o(rcmd)
  );

  awc_back #(.MaxColumns(MaxColumns), .MaxRows(MaxRows)) u_back (
    .clk_i, .rst_ni,
    .cols_i (cols_q),
    .rows_i (rows_q),
    .avail_i(avail),
    .cmd_i  (rcmd),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .kind_o (m_axis_tuser_o),
    .data_o (m_axis_tdata_o)
  );

endmodule

[tb/tb_ansi_utf8_terminal_cell_writer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ansi_utf8_terminal_cell_writer
// Self-checking bench for the terminal cell writer. Byte frames (text,
// UTF-8, control bytes, CSI colour / cursor / clear sequences, broken
// sequences and noise) are streamed in under random idling on both sides.
// A behavioral copy of the parser predicts each grid command, and every
// output word is checked field by field. Several grid sizes are set between
// phases, the clamped extremes among them.
// ----------------------------------------------------------------------------
module tb_ansi_utf8_terminal_cell_writer;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
  } byte_t;

  typedef struct {
    awc_pkg::cmd_kind_e kind;
    logic [16:0] idx;
    logic [20:0] cp;
    logic [7:0]  fr, fg, fb, br, bg, bb;
  } cell_cmd_t;

  localparam int WATCHDOG = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [87:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [9:0]  cfg_wdata_i = '0;

  ansi_utf8_terminal_cell_writer dut (.*);

  byte_t       pend_q[$];
  cell_cmd_t   cells_due[$];
  int          errors = 0;
  int          in_count = 0;
  int          gap = 0, hold = 0, idle_cycles = 0;
  logic        held = 1'b0, quiet = 1'b0;

  // predictor state
  logic [9:0]  grid_cols = awc_pkg::COLS_RESET;
  logic [8:0]  grid_rows = awc_pkg::ROWS_RESET;
  awc_pkg::parse_mode_e mode;
  logic [15:0] cur_col, cur_row, acc;
  logic [23:0] fore, back;
  logic        seen;
  logic [15:0] params[awc_pkg::MAX_PARAMS_DEF];
  int          pcnt;
  int          u_rem;
  logic [20:0] u_part;

  initial forever #10 clk_i = ~clk_i;

  function automatic int cols_eff();
    if (grid_cols == 0) return 1;
    if (grid_cols > awc_pkg::MAX_COLUMNS_DEF) return awc_pkg::MAX_COLUMNS_DEF;
    return grid_cols;
  endfunction

  function automatic int rows_eff();
    if (grid_rows == 0) return 1;
    if (grid_rows > awc_pkg::MAX_ROWS_DEF) return awc_pkg::MAX_ROWS_DEF;
    return grid_rows;
  endfunction

  task automatic frame_reset();
    mode = awc_pkg::MODE_GROUND;
    cur_col = '0;
    cur_row = '0;
    fore = {3{awc_pkg::FORE_RESET}};
    back = '0;
    acc = '0;
    seen = 1'b0;
    pcnt = 0;
    u_rem = 0;
    u_part = '0;
  endtask

  task automatic store_param(input logic [15:0] v);
    if (pcnt < awc_pkg::MAX_PARAMS_DEF) begin
      params[pcnt] = v;
      pcnt++;
    end
  endtask

  task automatic place_char(input logic [20:0] cp);
    cell_cmd_t c;
    int unsigned pos;
    if (cur_row < rows_eff() && cur_col < cols_eff()) begin
      pos = cur_row * cols_eff() + cur_col;
      c.kind = awc_pkg::CMD_WRITE;
      c.idx = pos[16:0];
      c.cp = cp;
      {c.fr, c.fg, c.fb} = fore;
      {c.br, c.bg, c.bb} = back;
      cells_due = {cells_due, c};
    end
    if (cur_col != awc_pkg::CUR_MAX) cur_col++;
  endtask

  task automatic apply_sgr();
    int k;
    if (pcnt == 0) store_param('0);
    for (k = 0; k < pcnt; k++) begin
      if (params[k] == 0) begin
        fore = {3{awc_pkg::FORE_RESET}};
        back = '0;
      end else if ((params[k] == awc_pkg::SGR_FORE || params[k] == awc_pkg::SGR_BACK)
                   && k + 4 < pcnt && params[k+1] == awc_pkg::SGR_RGB) begin
        if (params[k] == awc_pkg::SGR_FORE)
          fore = {params[k+2][7:0], params[k+3][7:0], params[k+4][7:0]};
        else
          back = {params[k+2][7:0], params[k+3][7:0], params[k+4][7:0]};
        k += 4;
      end
    end
  endtask

  task automatic seq_byte(input logic [7:0] b);
    logic [31:0] t;
    cell_cmd_t   c;
    if (b >= awc_pkg::CH_ZERO && b <= awc_pkg::CH_NINE) begin
      t = acc * 10 + (b - awc_pkg::CH_ZERO);
      acc = t[15:0];
      seen = 1'b1;
    end else if (b == awc_pkg::CH_SEMI) begin
      store_param(seen ? acc : 16'd0);
      acc = '0;
      seen = 1'b0;
    end else begin
      if (seen) store_param(acc);
      mode = awc_pkg::MODE_GROUND;
      acc = '0;
      seen = 1'b0;
      if (b == awc_pkg::CH_M) apply_sgr();
      else if (b == awc_pkg::CH_H || b == awc_pkg::CH_F) begin
        t = (pcnt >= 1) ? params[0] : 1;
        cur_row = (t > 0) ? t - 1 : 0;
        t = (pcnt >= 2) ? params[1] : 1;
        cur_col = (t > 0) ? t - 1 : 0;
      end else if (b == awc_pkg::CH_J) begin
        c = '{awc_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0};
        cells_due = {cells_due, c};
      end
      pcnt = 0;
    end
  endtask

  task automatic text_byte(input logic [7:0] b, input logic last);
    int need;
    logic [20:0] cp;
    need = 0;
    cp = {13'd0, b};
    if (b == awc_pkg::CH_ESC) mode = awc_pkg::MODE_ESCAPE;
    else if (b == awc_pkg::CH_LF) begin
      if (cur_row != awc_pkg::CUR_MAX) cur_row++;
      cur_col = '0;
    end else if (b == awc_pkg::CH_CR) cur_col = '0;
    else if (b >= 8'h20) begin
      if (b[7:5] == 3'b110) begin need = 1; cp = b[4:0]; end
      else if (b[7:4] == 4'b1110) begin need = 2; cp = b[3:0]; end
      else if (b[7:3] == 5'b11110) begin need = 3; cp = b[2:0]; end
      if (need == 0 || last) place_char(cp);
      else begin
        u_rem = need;
        u_part = cp;
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic first, input logic last);
    if (first) frame_reset();
    if (u_rem > 0) begin
      u_part = {u_part[14:0], b[5:0]};
      u_rem--;
      if (u_rem == 0 || last) begin
        u_rem = 0;
        place_char(u_part);
      end
    end else if (mode == awc_pkg::MODE_CSI) seq_byte(b);
    else if (mode == awc_pkg::MODE_ESCAPE && b == awc_pkg::CH_LBRK) begin
      mode = awc_pkg::MODE_CSI;
      acc = '0;
      seen = 1'b0;
      pcnt = 0;
    end else begin
      mode = awc_pkg::MODE_GROUND;
      text_byte(b, last);
    end
    if (last) begin
      mode = awc_pkg::MODE_GROUND;
      u_rem = 0;
      u_part = '0;
      acc = '0;
      seen = 1'b0;
      pcnt = 0;
    end
  endtask

  // ---- stimulus builders
  task automatic put(input logic [7:0] b, input logic f = 1'b0, input logic l = 1'b0);
    byte_t it;
    it.data = b;
    it.first = f;
    it.last = l;
    pend_q = {pend_q, it};
  endtask

  task automatic put_num(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    foreach (s[i]) put(s[i]);
  endtask

  task automatic put_csi();
    put(awc_pkg::CH_ESC);
    put(awc_pkg::CH_LBRK);
  endtask

  function automatic int unsigned rand_param();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 255);
      1: return $urandom_range(0, 999);
      2: return $urandom_range(0, 70000);
      default: return $urandom_range(0, 9);
    endcase
  endfunction

  task automatic put_piece(input int kind);
    int n;
    case (kind)
      0: put($urandom_range(8'h20, 8'h7e));
      1: begin
        n = $urandom_range(1, 3);
        if (n == 1) put(8'hc0 | $urandom_range(0, 31));
        else if (n == 2) put(8'he0 | $urandom_range(0, 15));
        else put(8'hf0 | $urandom_range(0, 7));
        repeat (n) put($urandom_range(0, 255));
      end
      2: begin
        put_csi();
        put_num($urandom_range(0, 1) ? 38 : 48);
        put(awc_pkg::CH_SEMI);
        put_num(2);
        repeat (3) begin put(awc_pkg::CH_SEMI); put_num(rand_param()); end
        put(awc_pkg::CH_M);
      end
      3: begin
        put_csi();
        case ($urandom_range(0, 3))
          0: put_num(0);
          1: ;
          2: begin
            put_num(38); put(awc_pkg::CH_SEMI); put_num(2);
            put(awc_pkg::CH_SEMI); put_num(9);
          end
          default: begin
            put_num(48); put(awc_pkg::CH_SEMI); put_num(5); put(awc_pkg::CH_SEMI);
          end
        endcase
        put(awc_pkg::CH_M);
      end
      4: begin
        put_csi();
        if ($urandom_range(0, 5) != 0) put_num($urandom_range(0, rows_eff() + 1));
        if ($urandom_range(0, 5) != 0) begin
          put(awc_pkg::CH_SEMI);
          put_num($urandom_range(0, cols_eff() + 1));
        end
        put($urandom_range(0, 1) ? awc_pkg::CH_H : awc_pkg::CH_F);
      end
      5: begin put_csi(); put(awc_pkg::CH_J); end
      6: put($urandom_range(0, 1) ? awc_pkg::CH_CR : awc_pkg::CH_LF);
      7: put($urandom_range(0, 255));
      8: begin put(awc_pkg::CH_ESC); put($urandom_range(0, 255)); end
      9: begin
        put_csi();
        n = $urandom_range(14, 20);
        repeat (n) begin put_num(rand_param()); put(awc_pkg::CH_SEMI); end
        put_num($urandom_range(0, 48));
        put($urandom_range(0, 3) == 0 ? $urandom_range(8'h40, 8'h7e) : awc_pkg::CH_M);
      end
      default: begin
        put_csi();
        put_num(rand_param());
        put($urandom_range(8'h20, 8'h7e));
      end
    endcase
  endtask

  task automatic build_frames(input int target);
    int start, stop, pieces;
    stop = pend_q.size() + target;
    while (pend_q.size() < stop) begin
      start = pend_q.size();
      pieces = $urandom_range(3, 12);
      repeat (pieces) put_piece($urandom_range(0, 14) > 10 ? $urandom_range(0, 1) :
                               $urandom_range(0, 10));
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: put(8'he0 | $urandom_range(0, 15));
          1: begin put_csi(); put_num(rand_param()); end
          default: put(awc_pkg::CH_ESC);
        endcase
      end
      if ($urandom_range(0, 7) != 0) pend_q[start].first = 1'b1;
      if ($urandom_range(0, 7) != 0) pend_q[$].last = 1'b1;
    end
  endtask

  task automatic set_grid(input logic [9:0] cols, input logic [9:0] rows);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= awc_pkg::REG_GRID_COLUMNS;
    cfg_wdata_i <= cols;
    @(posedge clk_i);
    cfg_idx_i <= awc_pkg::REG_GRID_ROWS;
    cfg_wdata_i <= rows;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_cols = cols;
    grid_rows = rows[8:0];
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || s_axis_tvalid_i || cells_due.size() > 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // ---- driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        decode_byte(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
        in_count <= in_count + 1;
      end
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (!quiet && pend_q.size() > 0 && $urandom_range(0, 7) == 0) begin
        gap <= $urandom_range(0, 4);
        s_axis_tvalid_i <= 1'b0;
      end else if (pend_q.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= pend_q[0].data;
        s_axis_tuser_i <= pend_q[0].first;
        s_axis_tlast_i <= pend_q[0].last;
        pend_q.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---- monitor and receiver
  always @(posedge clk_i) begin
    cell_cmd_t e;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (cells_due.size() == 0) begin
          $error("unexpected word: kind %0d data %h", m_axis_tuser_o, m_axis_tdata_o);
          errors++;
        end else begin
          e = cells_due.pop_front();
          if (m_axis_tuser_o !== e.kind) begin
            $error("command_kind: exp %0d got %0d", e.kind, m_axis_tuser_o); errors++;
          end
          if (m_axis_tdata_o[16:0] !== e.idx) begin
            $error("cell_index: exp %0d got %0d", e.idx, m_axis_tdata_o[16:0]); errors++;
          end
          if (m_axis_tdata_o[37:17] !== e.cp) begin
            $error("code_point: exp %h got %h", e.cp, m_axis_tdata_o[37:17]); errors++;
          end
          if (m_axis_tdata_o[45:38] !== e.fr) begin
            $error("fore_red: exp %0d got %0d", e.fr, m_axis_tdata_o[45:38]); errors++;
          end
          if (m_axis_tdata_o[53:46] !== e.fg) begin
            $error("fore_green: exp %0d got %0d", e.fg, m_axis_tdata_o[53:46]); errors++;
          end
          if (m_axis_tdata_o[61:54] !== e.fb) begin
            $error("fore_blue: exp %0d got %0d", e.fb, m_axis_tdata_o[61:54]); errors++;
          end
          if (m_axis_tdata_o[69:62] !== e.br) begin
            $error("back_red: exp %0d got %0d", e.br, m_axis_tdata_o[69:62]); errors++;
          end
          if (m_axis_tdata_o[77:70] !== e.bg) begin
            $error("back_green: exp %0d got %0d", e.bg, m_axis_tdata_o[77:70]); errors++;
          end
          if (m_axis_tdata_o[85:78] !== e.bb) begin
            $error("back_blue: exp %0d got %0d", e.bb, m_axis_tdata_o[85:78]); errors++;
          end
        end
      end
      if (hold > 0) begin
        hold <= hold - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!held && in_count > 300) begin
        held <= 1'b1;
        hold <= 80;
        m_axis_tready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold <= $urandom_range(0, 4);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ---- watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    ansi_utf8_terminal_cell_writer_run();
  end

  task automatic ansi_utf8_terminal_cell_writer_run();
    logic [9:0] grid_set[6][2];
    grid_set = '{'{10'd80, 10'd24}, '{10'd1, 10'd1}, '{10'd512, 10'd256},
                 '{10'd0, 10'd0}, '{10'd1023, 10'd511}, '{10'd37, 10'd5}};
    frame_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: controls, bad leads, lone escape, UTF-8, cut character
    put("A", 1'b1);
    put(8'h00); put(8'hff); put(8'h80);
    put(awc_pkg::CH_ESC); put("x");
    put(8'hc3); put(8'ha9);
    put(awc_pkg::CH_CR); put(awc_pkg::CH_LF);
    put(8'hf0); put(8'h9f, 1'b0, 1'b1);
    // cursor saturation, clear, escape on frame end
    put(awc_pkg::CH_ESC, 1'b1); put(awc_pkg::CH_LBRK); put(awc_pkg::CH_SEMI);
    put_num(65535); put(awc_pkg::CH_H);
    put("Z"); put("Z");
    put_csi(); put(awc_pkg::CH_J);
    put(awc_pkg::CH_ESC, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) set_grid(grid_set[p][0], grid_set[p][1]);
      if (p == 5) quiet <= 1'b1;
      build_frames(140);
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  endtask

endmodule

[files.f]
design/awc_pkg.sv
design/awc_front.sv
design/awc_fifo.sv
design/awc_back.sv
design/ansi_utf8_terminal_cell_writer.sv
tb/tb_ansi_utf8_terminal_cell_writer.sv
